>>> rtl/earliest_free_worker_scheduler_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the earliest free worker scheduler
// Concurrent property shorthands clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EARLIEST_FREE_WORKER_SCHEDULER_UNIT_DEFINES_SVH
`define EARLIEST_FREE_WORKER_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define EFWS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("efws assertion failed");

// Next-cycle implication.
`define EFWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("efws assertion failed");

`endif

>>> rtl/efws_pkg.sv
// ----------------------------------------------------------------------------
// Earliest free worker scheduler package
// Shared widths, reset values and controller/datapath interface types.
// ----------------------------------------------------------------------------
package efws_pkg;

  localparam int unsigned TIME_W          = 63;
  localparam int unsigned DUR_W           = 30;
  localparam int unsigned ID_W            = 4;
  localparam int unsigned CFG_W           = 5;
  localparam int unsigned DEF_NUM_WORKERS = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

endpackage

>>> rtl/efws_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module efws_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/efws_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences the accept, scan and update steps of one job.
// ----------------------------------------------------------------------------
module efws_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  efws_pkg::status_t status_i,
  output efws_pkg::cmd_t    cmd_o,
  output logic             done_o
);

  import efws_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.compare = 1'b1;
        if (status_i.last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.update;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

>>> rtl/efws_dpath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Free time memory, sequential minimum scan and saturating update.
// ----------------------------------------------------------------------------
module efws_dpath #(
  parameter int unsigned NUM_WORKERS = efws_pkg::DEF_NUM_WORKERS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  efws_pkg::cmd_t               cmd_i,
  output efws_pkg::status_t            status_o,
  input  logic [efws_pkg::CFG_W-1:0]  workers_in_use_i,
  input  logic [efws_pkg::DUR_W-1:0]  job_duration_i,
  output logic [efws_pkg::ID_W-1:0]   worker_id_o,
  output logic [efws_pkg::TIME_W-1:0] start_time_o
);

  import efws_pkg::*;

  localparam int unsigned IDX_W = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;

  logic [IDX_W-1:0]       last_idx;
  logic [IDX_W-1:0]       idx_q, cmp_idx_q;
  logic [DUR_W-1:0]       dur_q;
  logic [IDX_W-1:0]       best_id_q;
  logic [TIME_W-1:0]      best_time_q;
  logic [ID_W-1:0]        worker_id_q;
  logic [TIME_W-1:0]      start_time_q;
  logic [NUM_WORKERS-1:0] valid_q;
  logic                   valid_rd_q;
  logic [TIME_W-1:0]      rd_data;
  logic [TIME_W-1:0]      cur_time;
  logic [TIME_W:0]        sum;
  logic [TIME_W-1:0]      new_time;

  always_comb begin
    if (workers_in_use_i == '0) begin
      last_idx = '0;
    end else if (int'(workers_in_use_i) > NUM_WORKERS) begin
      last_idx = IDX_W'(NUM_WORKERS - 1);
    end else begin
      last_idx = IDX_W'(workers_in_use_i - 5'd1);
    end
  end

  efws_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_WORKERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (best_id_q),
    .wdata_i (new_time),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  assign cur_time = valid_rd_q ? rd_data : '0;
  assign sum      = {1'b0, best_time_q} + (TIME_W + 1)'(dur_q);
  assign new_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

  assign status_o.last = (cmp_idx_q == last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      cmp_idx_q  <= '0;
      valid_q    <= '0;
      valid_rd_q <= 1'b0;
    end else begin
      cmp_idx_q  <= idx_q;
      valid_rd_q <= valid_q[idx_q];
      if (cmd_i.update) begin
        idx_q              <= '0;
        valid_q[best_id_q] <= 1'b1;
      end else if ((cmd_i.load || cmd_i.compare) && (idx_q != last_idx)) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dur_q <= job_duration_i;
    end
    if (cmd_i.compare && ((cmp_idx_q == '0) || (cur_time < best_time_q))) begin
      best_time_q <= cur_time;
      best_id_q   <= cmp_idx_q;
    end
    if (cmd_i.update) begin
      worker_id_q  <= ID_W'(best_id_q);
      start_time_q <= best_time_q;
    end
  end

  assign worker_id_o  = worker_id_q;
  assign start_time_o = start_time_q;

endmodule

>>> rtl/earliest_free_worker_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Earliest free worker scheduler
// Assigns each job to the worker that becomes free first.
// ----------------------------------------------------------------------------
// A job duration is taken when start is high and busy is low. The block scans
// the free times of the workers in use, one worker per cycle from the free
// time memory, picks the earliest (lowest number on ties) and adds the
// duration to that worker's free time, saturating at the maximum.
// The result word (worker_id_o, start_time_o) is shown for one cycle with
// done_o high, after the scan of the workers in use and the update step that
// follow the accepting edge. A new job can be accepted in the done_o cycle,
// but not before: one job is done before the next one is taken.
// The results cannot be held off by the receiver.
// The workers-in-use register is written through cfg_valid_i/cfg_ready_o,
// always ready, and should be written only while the block is idle.
// Reset clears every free time to zero through per-worker valid bits, with
// no clearing pass, and sets the register to sixteen workers.
// ----------------------------------------------------------------------------
`include "earliest_free_worker_scheduler_unit_defines.svh"

module earliest_free_worker_scheduler_unit #(
  parameter int unsigned NUM_WORKERS = efws_pkg::DEF_NUM_WORKERS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [efws_pkg::DUR_W-1:0]  job_duration_i,
  output logic                        done_o,
  output logic [efws_pkg::ID_W-1:0]   worker_id_o,
  output logic [efws_pkg::TIME_W-1:0] start_time_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [efws_pkg::CFG_W-1:0]  cfg_data_i
);

  import efws_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic [CFG_W-1:0] workers_in_use_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      workers_in_use_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      workers_in_use_q <= cfg_data_i;
    end
  end

  efws_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd),
    .done_o   (done_o)
  );

  efws_dpath #(
    .NUM_WORKERS (NUM_WORKERS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .workers_in_use_i (workers_in_use_q),
    .job_duration_i   (job_duration_i),
    .worker_id_o      (worker_id_o),
    .start_time_o     (start_time_o)
  );

  `EFWS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `EFWS_ASSERT_NOW(a_done_idle, done_o, !busy)
  `EFWS_ASSERT_NEXT(a_done_single, done_o, !done_o)
  `EFWS_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0({cmd.load, cmd.compare, cmd.update}))

endmodule

>>> bench/earliest_free_worker_scheduler_unit_tb.sv
// ----------------------------------------------------------------------------
// Earliest free worker scheduler testbench
// Drives directed jobs, then job durations in random bursts; changes the number
// of workers in use between phases; checks every result word against a local
// scheduler model of each worker's free time, or against typed directed values.
// ----------------------------------------------------------------------------
module earliest_free_worker_scheduler_unit_tb;
  import efws_pkg::*;

  localparam int unsigned WORKERS = DEF_NUM_WORKERS;
  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned JOBS_PER_PHASE = 85;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam logic [DUR_W-1:0] DUR_MAX = '1;

  typedef struct packed {
    logic [ID_W-1:0]   worker_id;
    logic [TIME_W-1:0] start_time;
  } assignment_t;

  typedef struct {
    bit                is_cfg;
    logic [DUR_W-1:0]  value;
    bit                typed;
    logic [ID_W-1:0]   worker_id;
    logic [TIME_W-1:0] start_time;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [DUR_W-1:0]    job_duration_i = '0;
  logic                done_o;
  logic [ID_W-1:0]     worker_id_o;
  logic [TIME_W-1:0]   start_time_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_data_i = '0;

  logic [TIME_W-1:0]   worker_free_at [WORKERS];
  logic [CFG_W-1:0]    workers_in_use;
  assignment_t         pending_assignments [$];
  assignment_t         oldest;
  int unsigned         error_count = 0;
  stim_row_t           directed_rows [20];

  earliest_free_worker_scheduler_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .job_duration_i (job_duration_i),
    .done_o         (done_o),
    .worker_id_o    (worker_id_o),
    .start_time_o   (start_time_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  initial begin
    #3000000;
    $display("earliest_free_worker_scheduler_unit test failed");
    $finish;
  end

  function automatic assignment_t schedule_job(logic [DUR_W-1:0] dur);
    assignment_t r;
    int          n;
    int          best;
    logic [63:0] sum;
    n = workers_in_use;
    if (n < 1) n = 1;
    if (n > WORKERS) n = WORKERS;
    best = 0;
    for (int i = 1; i < n; i++) begin
      if (worker_free_at[i] < worker_free_at[best]) best = i;
    end
    r.worker_id = best[ID_W-1:0];
    r.start_time = worker_free_at[best];
    sum = {1'b0, worker_free_at[best]} + {34'd0, dur};
    worker_free_at[best] = sum[63] ? '1 : sum[TIME_W-1:0];
    return r;
  endfunction

  task automatic send_job(input logic [DUR_W-1:0] dur, input int unsigned gap,
                          input bit typed, input assignment_t typed_result);
    assignment_t predicted;
    start <= 1'b1;
    job_duration_i <= dur;
    do begin
      @(posedge clk_i);
    end while (busy);
    predicted = schedule_job(dur);
    pending_assignments.push_back(typed ? typed_result : predicted);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    while (pending_assignments.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_workers(input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    workers_in_use = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [DUR_W-1:0] random_duration();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) return '0;
    if (pick < 55) return DUR_W'($urandom_range(1, 15));
    if (pick < 65) return DUR_MAX;
    return DUR_W'($urandom);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_assignments.size() == 0) begin
        $display("%0t: unexpected result word, worker %0d start %0d", $time,
                 worker_id_o, start_time_o);
        error_count++;
      end else begin
        oldest = pending_assignments.pop_front();
        if (worker_id_o !== oldest.worker_id) begin
          $display("%0t: worker_id expected %0d actual %0d", $time,
                   oldest.worker_id, worker_id_o);
          error_count++;
        end
        if (start_time_o !== oldest.start_time) begin
          $display("%0t: start_time expected %0d actual %0d", $time,
                   oldest.start_time, start_time_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] phase_cfg [NUM_PHASES];
    int unsigned      burst_left;
    int unsigned      gap;
    bit               no_idle;
    assignment_t      typed_result;

    directed_rows = '{
      '{1'b0, 30'd0,         1'b1, 4'd0, 63'd0},
      '{1'b0, DUR_MAX,       1'b1, 4'd0, 63'd0},
      '{1'b0, 30'd1,         1'b1, 4'd1, 63'd0},
      '{1'b0, 30'd0,         1'b1, 4'd2, 63'd0},
      '{1'b0, 30'h2AAAAAAA,  1'b0, 4'd0, 63'd0},
      '{1'b1, 30'd0,         1'b0, 4'd0, 63'd0},
      '{1'b0, 30'd5,         1'b1, 4'd0, 63'h3FFFFFFF},
      '{1'b0, 30'h15555555,  1'b0, 4'd0, 63'd0},
      '{1'b1, 30'd31,        1'b0, 4'd0, 63'd0},
      '{1'b0, DUR_MAX,       1'b0, 4'd0, 63'd0},
      '{1'b0, DUR_MAX,       1'b0, 4'd0, 63'd0},
      '{1'b1, 30'd1,         1'b0, 4'd0, 63'd0},
      '{1'b0, 30'd9,         1'b0, 4'd0, 63'd0},
      '{1'b1, 30'd17,        1'b0, 4'd0, 63'd0},
      '{1'b0, 30'd0,         1'b0, 4'd0, 63'd0},
      '{1'b0, 30'd2,         1'b0, 4'd0, 63'd0},
      '{1'b1, 30'd2,         1'b0, 4'd0, 63'd0},
      '{1'b0, 30'h12345678,  1'b0, 4'd0, 63'd0},
      '{1'b0, 30'd3,         1'b0, 4'd0, 63'd0},
      '{1'b1, 30'd16,        1'b0, 4'd0, 63'd0}
    };

    for (int i = 0; i < WORKERS; i++) worker_free_at[i] = '0;
    workers_in_use = CFG_RESET;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        wait_idle();
        write_workers(directed_rows[r].value[CFG_W-1:0]);
      end else begin
        gap = (r == $size(directed_rows) - 1 || directed_rows[r + 1].is_cfg) ? 1 : 0;
        typed_result.worker_id = directed_rows[r].worker_id;
        typed_result.start_time = directed_rows[r].start_time;
        send_job(directed_rows[r].value, gap, directed_rows[r].typed, typed_result);
      end
    end

    phase_cfg = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd2, 5'd17, 5'd8, 5'd15, 5'd3, 5'd16};
    phase_cfg[6] = CFG_W'($urandom_range(0, 31));
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_workers(phase_cfg[p]);
      no_idle = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 12);
      for (int j = 0; j < JOBS_PER_PHASE; j++) begin
        if (j == JOBS_PER_PHASE - 1) begin
          gap = 1;
        end else if (no_idle || burst_left > 1) begin
          gap = 0;
        end else begin
          gap = $urandom_range(1, 8);
        end
        burst_left = (burst_left > 1) ? burst_left - 1 : $urandom_range(1, 12);
        send_job(random_duration(), gap, 1'b0, typed_result);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("earliest_free_worker_scheduler_unit test passed");
    end else begin
      $display("earliest_free_worker_scheduler_unit test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/efws_pkg.sv
rtl/efws_ram.sv
rtl/efws_ctrl.sv
rtl/efws_dpath.sv
rtl/earliest_free_worker_scheduler_unit.sv
bench/earliest_free_worker_scheduler_unit_tb.sv
